### hdl/orrt_pkg.sv
// Shared types, constants and octet compare functions for the IPv4 octet
// range rule table. No dependencies; every other file imports this package.
`default_nettype none

package orrt_pkg;

  localparam int unsigned MAX_RULES_DEF = 16;
  localparam int unsigned OCTETS_DEF    = 4;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned OCT_W         = 8;
  localparam int unsigned WORD_OCTETS   = WORD_W / OCT_W;
  localparam int unsigned STATUS_W      = 3;

  // Queue between the front and the back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_MATCHED  = 3'd1,
    ST_NOMATCH  = 3'd2,
    ST_BADRANGE = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic              lookup;
    logic              bad_range;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] addr;
  } rq_t;

  // Octet i of a field sits at bit 8*(octets-1-i), so only the lowest
  // min(octets, 4) bytes carry data; higher bytes are not compared.
  function automatic logic range_ok(input logic [WORD_W-1:0] lo,
                                    input logic [WORD_W-1:0] hi,
                                    input int unsigned octets);
    logic ok;
    ok = 1'b1;
    for (int unsigned j = 0; j < WORD_OCTETS; j++) begin
      if (j < octets && hi[j*OCT_W +: OCT_W] < lo[j*OCT_W +: OCT_W]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic rule_holds(input logic [WORD_W-1:0] lo,
                                      input logic [WORD_W-1:0] hi,
                                      input logic [WORD_W-1:0] addr,
                                      input int unsigned octets);
    logic ok;
    ok = 1'b1;
    for (int unsigned j = 0; j < WORD_OCTETS; j++) begin
      if (j < octets && (addr[j*OCT_W +: OCT_W] < lo[j*OCT_W +: OCT_W] ||
                         addr[j*OCT_W +: OCT_W] > hi[j*OCT_W +: OCT_W])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

### hdl/orrt_ifs.sv
// Request and response channel interfaces of the rule table.
// Depends on orrt_pkg for field widths and the status type.
`default_nettype none

interface orrt_req_if import orrt_pkg::*;;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [WORD_W-1:0] rule_low;
  logic [WORD_W-1:0] rule_high;
  logic [WORD_W-1:0] lookup_addr;

  modport source (output valid, opcode, rule_low, rule_high, lookup_addr, input ready);
  modport sink   (input valid, opcode, rule_low, rule_high, lookup_addr, output ready);
endinterface

interface orrt_rsp_if import orrt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                matched;

  modport source (output valid, status, matched, input ready);
  modport sink   (input valid, status, matched, output ready);
endinterface

`default_nettype wire

### hdl/orrt_front.sv
// Front stage: accepts requests, checks the bounds of add requests and
// registers the classified request. Depends on orrt_pkg and orrt_req_if.
`default_nettype none

module orrt_front import orrt_pkg::*; #(
  parameter int unsigned OCTETS = OCTETS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  orrt_req_if.sink   req,
  output logic       stg_valid,
  input  logic       stg_ready,
  output rq_t        stg
);

  assign req.ready = !stg_valid || stg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req.ready) begin
      stg_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stg.lookup    <= (req.opcode == OP_LOOKUP);
      stg.bad_range <= (req.opcode == OP_ADD) &&
                       !range_ok(req.rule_low, req.rule_high, OCTETS);
      stg.lo        <= req.rule_low;
      stg.hi        <= req.rule_high;
      stg.addr      <= req.lookup_addr;
    end
  end

endmodule

`default_nettype wire

### hdl/orrt_queue.sv
// Short request queue that decouples the front stage from the back end.
// Depends on orrt_pkg for the request type and the queue depth.
`default_nettype none

module orrt_queue import orrt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rq_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output rq_t  out_data
);

  rq_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;
  logic               push;
  logic               pop;

  assign in_ready  = (fill != Q_CNT_W'(Q_DEPTH));
  assign out_valid = (fill != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

### hdl/orrt_back.sv
// Back end: holds the rule memory and rule count, stores added rules and
// walks the stored rules one per cycle for a lookup. Depends on orrt_pkg.
`default_nettype none

module orrt_back import orrt_pkg::*; #(
  parameter int unsigned MAX_RULES = MAX_RULES_DEF,
  parameter int unsigned OCTETS    = OCTETS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_ready,
  input  rq_t        q_data,
  orrt_rsp_if.source rsp
);

  localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    rule_count;
  logic [IDX_W-1:0]    cmp_idx;
  logic [WORD_W-1:0]   addr;
  logic                out_valid;
  status_t             out_status;
  logic                out_matched;

  logic [2*WORD_W-1:0] rules [MAX_RULES];
  logic [2*WORD_W-1:0] rd_data;
  logic [IDX_W-1:0]    rd_addr;

  logic                out_free;
  logic                pop;
  logic                wr_en;
  logic                last;
  logic                hit;
  logic                rsp_done;

  assign out_free = !out_valid || rsp.ready;
  assign pop      = (state == S_IDLE) && q_valid && out_free;
  assign q_ready  = pop;
  assign wr_en    = pop && !q_data.lookup && !q_data.bad_range &&
                    (rule_count != CNT_W'(MAX_RULES));
  // The first rule is fetched as the lookup leaves the queue; each walk
  // cycle compares the fetched rule and fetches the one after it.
  assign rd_addr  = (state == S_IDLE) ? '0 : cmp_idx + IDX_W'(1);
  assign last     = (CNT_W'(cmp_idx) + CNT_W'(1)) == rule_count;
  assign hit      = rule_holds(rd_data[2*WORD_W-1:WORD_W], rd_data[WORD_W-1:0],
                               addr, OCTETS);
  // A result is produced this cycle: an add or an empty-table lookup as it
  // leaves the queue, or the end of a walk.
  assign rsp_done = pop ? (!q_data.lookup || (rule_count == '0))
                        : ((state == S_WALK) && (hit || last));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rules[rule_count[IDX_W-1:0]] <= {q_data.lo, q_data.hi};
    end
    rd_data <= rules[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rule_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (rsp_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (!q_data.lookup) begin
              out_matched <= 1'b0;
              if (q_data.bad_range) begin
                out_status <= ST_BADRANGE;
              end else if (rule_count == CNT_W'(MAX_RULES)) begin
                out_status <= ST_FULL;
              end else begin
                out_status <= ST_ADDED;
                rule_count <= rule_count + CNT_W'(1);
              end
            end else if (rule_count == '0) begin
              out_status  <= ST_NOMATCH;
              out_matched <= 1'b0;
            end else begin
              addr    <= q_data.addr;
              cmp_idx <= '0;
              state   <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (hit || last) begin
            out_status  <= hit ? ST_MATCHED : ST_NOMATCH;
            out_matched <= hit;
            state       <= S_IDLE;
          end else begin
            cmp_idx <= cmp_idx + IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.matched = out_matched;

endmodule

`default_nettype wire

### hdl/ipv4_octet_range_rule_table_core.sv
// IPv4 octet range rule table.
// Requests arrive on req (valid/ready): opcode 0 adds a rule given by packed
// octet bounds rule_low/rule_high, opcode 1 looks up lookup_addr. Each request
// gives one response on rsp (valid/ready) with status and matched.
// A request is registered by the front stage, where add bounds are checked,
// and waits in a two-entry queue for the back end. An add is handled as it
// leaves the queue; a lookup then walks up to MAX_RULES stored rules one per
// cycle and stops at the first matching rule. The rule memory's one read
// port, read once per cycle, sets the walk rate. A request passes the front
// register and the queue; the back end then registers its response in the
// output register, after the walk for a lookup.
// Reset clears the rule count, so the table starts empty; stored bounds are
// never compared before they are written.
// When rsp is stalled the result waits in the output register; the back end
// stops at the next request and the front keeps taking requests until the
// queue and the front register are full, then drops req.ready.
`default_nettype none

module ipv4_octet_range_rule_table_core import orrt_pkg::*; #(
  parameter int unsigned MAX_RULES = MAX_RULES_DEF,
  parameter int unsigned OCTETS    = OCTETS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  orrt_req_if.sink   req,
  orrt_rsp_if.source rsp
);

  logic stg_valid;
  logic stg_ready;
  rq_t  stg;
  logic q_valid;
  logic q_ready;
  rq_t  q_data;

  orrt_front #(
    .OCTETS (OCTETS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .stg_valid (stg_valid),
    .stg_ready (stg_ready),
    .stg       (stg)
  );

  orrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid),
    .in_ready  (stg_ready),
    .in_data   (stg),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  orrt_back #(
    .MAX_RULES (MAX_RULES),
    .OCTETS    (OCTETS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .rsp     (rsp)
  );

`ifndef SYNTHESIS
  // Only add requests can carry a bounds error.
  a_lookup_no_bad_range: assert property (@(posedge clk) disable iff (rst)
    stg_valid && stg.lookup |-> !stg.bad_range)
    else $error("lookup request classified with a bad range");

  // Add results never report a match.
  a_add_not_matched: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_ADDED || rsp.status == ST_BADRANGE ||
                  rsp.status == ST_FULL) |-> !rsp.matched)
    else $error("add result reports a match");

  // The matched flag agrees with the lookup status.
  a_match_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_MATCHED || rsp.status == ST_NOMATCH) |->
      (rsp.matched == (rsp.status == ST_MATCHED)))
    else $error("matched flag disagrees with lookup status");

  // Right after reset, no response is valid.
  a_no_early_rsp: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

### sim/tb_ipv4_octet_range_rule_table_core.sv
// Self-checking testbench for ipv4_octet_range_rule_table_core: add and lookup
// requests with random stalls on both channels, checked against a rule table kept here.
// Depends on orrt_pkg, the orrt_req_if and orrt_rsp_if interfaces, and the core.
`default_nettype none

module tb_ipv4_octet_range_rule_table_core;
  import orrt_pkg::*;

  localparam int RANDOM_REQUESTS = 400;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int CALM_TAIL       = 40;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct {
    opcode_t op;
    word_t   lo;
    word_t   hi;
    word_t   addr;
    bit      drain;
  } table_req_t;

  typedef struct {
    status_t status;
    logic    matched;
  } verdict_t;

  logic clk;
  logic rst;

  orrt_req_if req_ch ();
  orrt_rsp_if rsp_ch ();

  ipv4_octet_range_rule_table_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  table_req_t pending_requests[$];
  verdict_t   awaited_verdicts[$];
  word_t      planned_lo[$];
  word_t      planned_hi[$];

  // Rule table as the block should hold it.
  word_t       table_lo [MAX_RULES_DEF];
  word_t       table_hi [MAX_RULES_DEF];
  int unsigned rules_held;

  int  error_count;
  int  requests_sent;
  int  adds_stored, adds_bad, adds_full, lookups_hit, lookups_miss;
  int  cycle_count;
  logic req_taken;
  int  src_gap;
  int  sink_stall;

  // Octet j counts from the first octet, which sits in the top byte.
  function automatic bit bounds_in_order(word_t lo, word_t hi);
    for (int j = 0; j < OCTETS_DEF; j++) begin
      if (hi[8*(3-j) +: 8] < lo[8*(3-j) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit addr_in_rule(word_t lo, word_t hi, word_t addr);
    for (int j = 0; j < OCTETS_DEF; j++) begin
      if (addr[8*(3-j) +: 8] < lo[8*(3-j) +: 8] || addr[8*(3-j) +: 8] > hi[8*(3-j) +: 8])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t apply_request(opcode_t op, word_t lo, word_t hi, word_t addr);
    verdict_t v;
    v.matched = 1'b0;
    if (op == OP_ADD) begin
      if (!bounds_in_order(lo, hi)) begin
        v.status = ST_BADRANGE;
      end else if (rules_held >= MAX_RULES_DEF) begin
        v.status = ST_FULL;
      end else begin
        table_lo[rules_held] = lo;
        table_hi[rules_held] = hi;
        rules_held++;
        v.status = ST_ADDED;
      end
    end else begin
      for (int k = 0; k < rules_held; k++) begin
        if (addr_in_rule(table_lo[k], table_hi[k], addr)) v.matched = 1'b1;
      end
      v.status = v.matched ? ST_MATCHED : ST_NOMATCH;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Stimulus builders. The planned rule list mirrors what the table will hold,
  // so lookups can be aimed at stored rules.
  function automatic void queue_add(word_t lo, word_t hi, bit drain);
    table_req_t r;
    r.op    = OP_ADD;
    r.lo    = lo;
    r.hi    = hi;
    r.addr  = $urandom();
    r.drain = drain;
    pending_requests.insert(pending_requests.size(), r);
    if (bounds_in_order(lo, hi) && planned_lo.size() < MAX_RULES_DEF) begin
      planned_lo.insert(planned_lo.size(), lo);
      planned_hi.insert(planned_hi.size(), hi);
    end
  endfunction

  function automatic void queue_lookup(word_t addr, bit drain);
    table_req_t r;
    r.op    = OP_LOOKUP;
    r.lo    = $urandom();
    r.hi    = $urandom();
    r.addr  = addr;
    r.drain = drain;
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic void make_rule(output word_t lo, output word_t hi);
    int a, b;
    lo = '0;
    hi = '0;
    for (int j = 0; j < 4; j++) begin
      case ($urandom_range(0, 3))
        0: begin
          a = $urandom_range(0, 255);
          b = a;
        end
        1: begin
          a = 0;
          b = 255;
        end
        default: begin
          a = $urandom_range(0, 255);
          b = $urandom_range(a, 255);
        end
      endcase
      lo[8*j +: 8] = a[7:0];
      hi[8*j +: 8] = b[7:0];
    end
  endfunction

  function automatic word_t aim_at_rule(int k, bit at_border);
    word_t a, lo, hi;
    int lo_o, hi_o, j;
    lo = planned_lo[k];
    hi = planned_hi[k];
    a  = '0;
    for (int i = 0; i < 4; i++) begin
      lo_o = lo[8*i +: 8];
      hi_o = hi[8*i +: 8];
      a[8*i +: 8] = 8'($urandom_range(lo_o, hi_o));
    end
    if (at_border) begin
      j    = $urandom_range(0, 3);
      lo_o = lo[8*j +: 8];
      hi_o = hi[8*j +: 8];
      if (lo_o > 0 && (hi_o == 255 || $urandom_range(0, 1) == 1)) a[8*j +: 8] = 8'(lo_o - 1);
      else if (hi_o < 255) a[8*j +: 8] = 8'(hi_o + 1);
    end
    return a;
  endfunction

  function automatic void build_directed();
    // Lookups on the empty table.
    queue_lookup(32'h0000_0000, 1'b0);
    queue_lookup(32'hFFFF_FFFF, 1'b0);
    // Bad range in each single octet, then in all octets at once.
    for (int j = 0; j < 4; j++) begin
      word_t lo, hi;
      lo = 32'h0000_0000;
      hi = 32'hFFFF_FFFF;
      lo[8*j +: 8] = 8'h80;
      hi[8*j +: 8] = 8'h7F;
      queue_add(lo, hi, 1'b0);
    end
    queue_add(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    // A single host, probed on and beside it.
    queue_add(32'h0A01_0203, 32'h0A01_0203, 1'b0);
    queue_lookup(32'h0A01_0203, 1'b1);
    queue_lookup(32'h0A01_0204, 1'b0);
    queue_lookup(32'h0A01_0202, 1'b0);
    // Wildcards in the last two octets.
    queue_add(32'hC0A8_0000, 32'hC0A8_FFFF, 1'b0);
    queue_lookup(32'hC0A8_0000, 1'b0);
    queue_lookup(32'hC0A8_FFFF, 1'b0);
    queue_lookup(32'hC0A9_0000, 1'b0);
    queue_lookup(32'hC0A7_FFFF, 1'b0);
    // Bounds apply per octet: this address lies numerically between them but
    // its second octet is below the low bound.
    queue_add(32'h0102_0304, 32'h0506_0708, 1'b0);
    queue_lookup(32'h0301_0505, 1'b0);
    queue_lookup(32'h0304_0506, 1'b0);
    // Extreme hosts.
    queue_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_add(32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_lookup(32'hFFFF_FFFF, 1'b0);
    queue_lookup(32'h0000_0000, 1'b0);
  endfunction

  function automatic void build_random();
    word_t lo, hi;
    int pick, sel, j, b;
    bit drain;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      drain = ($urandom_range(0, 49) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 15) begin
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
          make_rule(lo, hi);
        end else if (sel < 17) begin
          // Well-formed apart from one octet.
          make_rule(lo, hi);
          j = $urandom_range(0, 3);
          b = hi[8*j +: 8];
          if (b < 255) begin
            lo[8*j +: 8] = 8'($urandom_range(b + 1, 255));
          end else begin
            hi[8*j +: 8] = 8'($urandom_range(0, 254));
            lo[8*j +: 8] = 8'hFF;
          end
        end else begin
          lo = $urandom();
          hi = $urandom();
        end
        queue_add(lo, hi, drain);
      end else if (planned_lo.size() > 0 && pick < 60) begin
        queue_lookup(aim_at_rule($urandom_range(0, planned_lo.size() - 1), 1'b0), drain);
      end else if (planned_lo.size() > 0 && pick < 75) begin
        queue_lookup(aim_at_rule($urandom_range(0, planned_lo.size() - 1), 1'b1), drain);
      end else begin
        queue_lookup($urandom(), drain);
      end
    end
    // A full wildcard at the end, when the table should be full.
    queue_add(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_lookup($urandom(), 1'b0);
  endfunction

  // Request driver.
  always @(negedge clk) begin
    table_req_t r;
    bit quiet, holding;
    quiet = ((requests_sent / 60) % 4 == 3) || (pending_requests.size() < CALM_TAIL);
    holding = req_ch.valid && !req_taken;
    if (!rst && !holding) begin
      if (src_gap > 0) begin
        src_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].drain && awaited_verdicts.size() != 0)) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 14) - 1;
          req_ch.valid <= 1'b0;
        end else begin
          r = pending_requests.pop_front();
          req_ch.opcode      <= r.op;
          req_ch.rule_low    <= r.lo;
          req_ch.rule_high   <= r.hi;
          req_ch.lookup_addr <= r.addr;
          req_ch.valid       <= 1'b1;
          requests_sent++;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response ready driver.
  always @(negedge clk) begin
    bit quiet;
    quiet = ((requests_sent / 60) % 4 == 3) || (pending_requests.size() < CALM_TAIL);
    if (!rst) begin
      if (sink_stall > 0) begin
        sink_stall--;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sink_stall = $urandom_range(1, 14) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted request, check every accepted response.
  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_verdicts.size() == 0) begin
          report_mismatch("responses outstanding", 0, 1);
        end else begin
          v = awaited_verdicts.pop_front();
          if (rsp_ch.status !== v.status) report_mismatch("status", rsp_ch.status, v.status);
          if (rsp_ch.matched !== v.matched) report_mismatch("matched", rsp_ch.matched, v.matched);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        v = apply_request(opcode_t'(req_ch.opcode), req_ch.rule_low, req_ch.rule_high,
                          req_ch.lookup_addr);
        case (v.status)
          ST_ADDED:    adds_stored++;
          ST_BADRANGE: adds_bad++;
          ST_FULL:     adds_full++;
          ST_MATCHED:  lookups_hit++;
          default:     lookups_miss++;
        endcase
        awaited_verdicts.insert(awaited_verdicts.size(), v);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, awaited_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.opcode      = OP_ADD;
    req_ch.rule_low    = '0;
    req_ch.rule_high   = '0;
    req_ch.lookup_addr = '0;
    rsp_ch.ready       = 1'b0;
    rules_held         = 0;
    error_count        = 0;
    requests_sent      = 0;
    adds_stored        = 0;
    adds_bad           = 0;
    adds_full          = 0;
    lookups_hit        = 0;
    lookups_miss       = 0;
    cycle_count        = 0;
    src_gap            = 0;
    sink_stall         = 0;
    build_directed();
    build_random();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_requests.size() != 0 || req_ch.valid) @(posedge clk);
    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d requests: %0d rules stored, %0d bad ranges, %0d adds on a full table,",
             requests_sent, adds_stored, adds_bad, adds_full);
    $display("and %0d lookups that matched and %0d that did not.", lookups_hit, lookups_miss);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/orrt_pkg.sv
hdl/orrt_ifs.sv
hdl/orrt_front.sv
hdl/orrt_queue.sv
hdl/orrt_back.sv
hdl/ipv4_octet_range_rule_table_core.sv
sim/tb_ipv4_octet_range_rule_table_core.sv
